### sv/mfb_pkg.sv
// Shared constants, types and tables of the momentum fraction budget filter.
`timescale 1ns / 1ps
`default_nettype none

package mfb_pkg;

    // Result codes carried in the verdict field.
    typedef logic [2:0] verdict_t;
    localparam verdict_t VERDICT_KEPT    = 3'd0;
    localparam verdict_t VERDICT_SKIPPED = 3'd1;
    localparam verdict_t VERDICT_P_OVER  = 3'd2;
    localparam verdict_t VERDICT_T_OVER  = 3'd3;
    localparam verdict_t VERDICT_BOTH    = 3'd4;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_ENERGY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPLETE_ENABLE = 1'd1;
    localparam logic [31:0] INVERSE_ENERGY_RESET = 32'd855573;

    // Euler's number and its reciprocal in Q32.
    localparam logic [63:0] E_Q32     = 64'h0000_0002_B7E1_5163;
    localparam logic [63:0] INV_E_Q32 = 64'h0000_0000_5E2D_58D9;

    // Event tag stored with every slot entry.
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'hFF;

    // Number of Taylor terms in the fraction series.
    localparam logic [3:0] SERIES_TERMS = 4'd14;

    // floor(2^36 / k) for the series divisors.
    function automatic logic [36:0] recip_q36(input logic [3:0] k);
        logic [36:0] m;
        unique case (k)
            4'd1:    m = 37'd68719476736;
            4'd2:    m = 37'd34359738368;
            4'd3:    m = 37'd22906492245;
            4'd4:    m = 37'd17179869184;
            4'd5:    m = 37'd13743895347;
            4'd6:    m = 37'd11453246122;
            4'd7:    m = 37'd9817068105;
            4'd8:    m = 37'd8589934592;
            4'd9:    m = 37'd7635497415;
            4'd10:   m = 37'd6871947673;
            4'd11:   m = 37'd6247225157;
            4'd12:   m = 37'd5726623061;
            4'd13:   m = 37'd5286113595;
            4'd14:   m = 37'd4908534052;
            default: m = 37'd0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

### sv/mfb_mulq.sv
// Four-step Q32 multiplier: floor(a * b / 2^32) modulo 2^64 from 32x32 partial products.
`timescale 1ns / 1ps
`default_nettype none

module mfb_mulq
    import mfb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             done,
    output logic [63:0]      result
);

    logic        busy_reg;
    logic        done_reg;
    logic [1:0]  step_reg;
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] acc_reg;
    logic [31:0] op_x;
    logic [31:0] op_y;
    logic [63:0] prod;

    // Partial product order: low-low, low-high, high-low, high-high.
    always_comb
    begin
        unique case (step_reg)
            2'd0:
            begin
                op_x = a_reg[31:0];
                op_y = b_reg[31:0];
            end
            2'd1:
            begin
                op_x = a_reg[31:0];
                op_y = b_reg[63:32];
            end
            2'd2:
            begin
                op_x = a_reg[63:32];
                op_y = b_reg[31:0];
            end
            default:
            begin
                op_x = a_reg[63:32];
                op_y = b_reg[63:32];
            end
        endcase
        prod = op_x * op_y;
    end

    // Step control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 2'd1;
            if (step_reg == 2'd3)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Operands and accumulator.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        else if (busy_reg)
        begin
            unique case (step_reg)
                2'd0:    acc_reg <= {32'd0, prod[63:32]};
                2'd1:    acc_reg <= acc_reg + prod;
                2'd2:    acc_reg <= acc_reg + prod;
                default: acc_reg <= acc_reg + {prod[31:0], 32'd0};
            endcase
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

`default_nettype wire

### sv/mfb_exp.sv
// Sequential exponential unit: Taylor series of the fraction, then scaling by e or 1/e.
`timescale 1ns / 1ps
`default_nettype none

module mfb_exp
    import mfb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [16:0] y,
    output logic             done,
    output logic [47:0]      value
);

    localparam logic [2:0] E_IDLE  = 3'd0;
    localparam logic [2:0] E_MUL1  = 3'd1;
    localparam logic [2:0] E_MUL2  = 3'd2;
    localparam logic [2:0] E_CORR  = 3'd3;
    localparam logic [2:0] E_SCALE = 3'd4;
    localparam logic [2:0] E_WAIT  = 3'd5;

    logic [2:0]  state_reg;
    logic        done_reg;
    logic [3:0]  k_reg;
    logic [3:0]  cnt_reg;
    logic        up_reg;
    logic [11:0] frac_reg;
    logic [32:0] term_reg;
    logic [31:0] a_reg;
    logic [31:0] q_reg;
    logic [47:0] v_reg;

    logic [16:0] u;
    logic [4:0]  n;
    logic [44:0] tf_prod;
    logic [68:0] qm_prod;
    logic [35:0] qk_prod;
    logic [31:0] rem;
    logic [32:0] term_new;
    logic        mul_start;
    logic        mul_done;
    logic [63:0] mul_result;

    // Offset rapidity: integer part 0..16 and a 12-bit fraction.
    assign u = y + 17'h08000;
    assign n = u[16:12];

    // Series datapath, one registered multiply per cycle.
    always_comb
    begin
        tf_prod  = term_reg * frac_reg;
        qm_prod  = a_reg * recip_q36(k_reg);
        qk_prod  = q_reg * k_reg;
        rem      = a_reg - qk_prod[31:0];
        term_new = {1'b0, q_reg} + 33'(rem >= {28'd0, k_reg});
    end

    assign mul_start = (state_reg == E_SCALE) && (cnt_reg != 4'd0);

    mfb_mulq u_mulq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      ({16'd0, v_reg}),
        .b      (up_reg ? E_Q32 : INV_E_Q32),
        .done   (mul_done),
        .result (mul_result)
    );

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
            k_reg     <= 4'd1;
            cnt_reg   <= 4'd0;
        end
        else if (start)
        begin
            state_reg <= E_MUL1;
            done_reg  <= 1'b0;
            k_reg     <= 4'd1;
            cnt_reg   <= (n >= 5'd8) ? 4'(n - 5'd8) : 4'(5'd8 - n);
        end
        else
        begin
            unique case (state_reg)
                E_IDLE: ;
                E_MUL1:  state_reg <= E_MUL2;
                E_MUL2:  state_reg <= E_CORR;
                E_CORR:
                begin
                    if (k_reg == SERIES_TERMS)
                    begin
                        state_reg <= E_SCALE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 4'd1;
                        state_reg <= E_MUL1;
                    end
                end
                E_SCALE:
                begin
                    if (cnt_reg == 4'd0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= E_IDLE;
                    end
                    else
                    begin
                        state_reg <= E_WAIT;
                    end
                end
                E_WAIT:
                begin
                    if (mul_done)
                    begin
                        cnt_reg   <= cnt_reg - 4'd1;
                        state_reg <= E_SCALE;
                    end
                end
                default: state_reg <= E_IDLE;
            endcase
        end
    end

    // Series and scaling data registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            frac_reg <= u[11:0];
            up_reg   <= (n >= 5'd8);
            term_reg <= 33'h1_0000_0000;
            v_reg    <= 48'h1_0000_0000;
        end
        else
        begin
            if (state_reg == E_MUL1)
            begin
                a_reg <= tf_prod[43:12];
            end
            if (state_reg == E_MUL2)
            begin
                q_reg <= qm_prod[67:36];
            end
            if (state_reg == E_CORR)
            begin
                term_reg <= term_new;
                v_reg    <= v_reg + {15'd0, term_new};
            end
            if ((state_reg == E_WAIT) && mul_done)
            begin
                v_reg <= mul_result[47:0];
            end
        end
    end

    assign done  = done_reg;
    assign value = v_reg;

endmodule

`default_nettype wire

### sv/momentum_fraction_budget_filter.sv
// Momentum fraction budget filter top level: control, slot memories and charging.
// An accepted beat is read from the slot memories and checked for depletion; four
// exponential units (14 series terms, then 0 to 8 scaling products by e or 1/e), a
// fraction product and the slot update follow; a skipped beat goes from the check
// straight to its result beat. Throughput: one item at a time.
// Reset runs a clearing pass over all slots, repeated when the 255-event tag wraps.
`timescale 1ns / 1ps
`default_nettype none

module momentum_fraction_budget_filter
    import mfb_pkg::*;
#(
    parameter int NUCLEON_SLOTS = 256,
    parameter int SUM_WIDTH     = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // transverse_momentum[19:0], rapidity_one[35:20], rapidity_two[51:36],
    // projectile_index[59:52], target_index[67:60], zero fill[71:68]
    input  wire logic [71:0]          s_tdata,
    // first_of_event
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // accepted[0], verdict[3:1], zero fill[7:4]
    output logic [7:0]                m_tdata,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    localparam int IDX_W = (NUCLEON_SLOTS > 1) ? $clog2(NUCLEON_SLOTS) : 1;
    localparam int ENT_W = EPOCH_W + 1 + SUM_WIDTH;
    localparam int SHR   = 50 - SUM_WIDTH;
    localparam logic [SUM_WIDTH-1:0] SUM_ONE = {2'b01, {(SUM_WIDTH-2){1'b0}}};
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(NUCLEON_SLOTS - 1);

    localparam logic [3:0] ST_SWEEP = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_READ  = 4'd2;
    localparam logic [3:0] ST_CHECK = 4'd3;
    localparam logic [3:0] ST_EXP   = 4'd4;
    localparam logic [3:0] ST_MUL   = 4'd5;
    localparam logic [3:0] ST_MULW  = 4'd6;
    localparam logic [3:0] ST_CHG   = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    // Reduce an index modulo the slot count by shifted compare and subtract.
    function automatic logic [7:0] slot_of(input logic [7:0] idx);
        logic [19:0] rem;
        rem = {12'd0, idx};
        for (int s = 7; s >= 0; s--)
        begin
            if (rem >= (20'(NUCLEON_SLOTS) << s))
            begin
                rem = rem - (20'(NUCLEON_SLOTS) << s);
            end
        end
        return rem[7:0];
    endfunction

    // Bring a Q32 fraction to the sum format, saturating.
    function automatic logic [SUM_WIDTH-1:0] to_sum(input logic [63:0] x);
        logic [49:0] w;
        w = {x[33:0], 16'd0};
        return (|x[63:34]) ? {SUM_WIDTH{1'b1}} : SUM_WIDTH'(w >> SHR);
    endfunction

    // Charge one slot entry; returns {over, new entry}.
    function automatic logic [ENT_W:0] charge(input logic [ENT_W-1:0] ent,
                                              input logic [SUM_WIDTH-1:0] x,
                                              input logic [EPOCH_W-1:0] epoch,
                                              input logic dep_en);
        logic [SUM_WIDTH:0]   wide;
        logic [SUM_WIDTH-1:0] s;
        logic                 dep;
        logic                 over;
        if (ent[ENT_W-1 -: EPOCH_W] != epoch)
        begin
            // First charge of this event is stored unchecked.
            s    = x;
            dep  = 1'b0;
            over = 1'b0;
        end
        else
        begin
            wide = {1'b0, ent[SUM_WIDTH-1:0]} + {1'b0, x};
            s    = wide[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : wide[SUM_WIDTH-1:0];
            over = (s > SUM_ONE);
            dep  = ent[SUM_WIDTH] | (over & dep_en);
        end
        return {over, epoch, dep, s};
    endfunction

    logic [3:0]           state_reg;
    logic                 busy_reg;
    logic [IDX_W-1:0]     sweep_cnt_reg;
    logic [EPOCH_W-1:0]   epoch_reg;
    logic [31:0]          inverse_energy_reg;
    logic                 deplete_enable_reg;
    logic                 m_tvalid_reg;
    logic [7:0]           m_tdata_reg;
    logic                 accepted_reg;
    verdict_t             verdict_reg;

    logic [19:0]          kt_reg;
    logic [16:0]          y1_reg;
    logic [16:0]          y2_reg;
    logic [IDX_W-1:0]     p_idx_reg;
    logic [IDX_W-1:0]     t_idx_reg;
    logic [43:0]          ratio_reg;
    logic [63:0]          sum1_reg;
    logic [63:0]          sum2_reg;
    logic [SUM_WIDTH-1:0] x1_reg;
    logic [SUM_WIDTH-1:0] x2_reg;
    logic [ENT_W-1:0]     pent_reg;
    logic [ENT_W-1:0]     tent_reg;

    logic [ENT_W-1:0]     pmem [NUCLEON_SLOTS];
    logic [ENT_W-1:0]     tmem [NUCLEON_SLOTS];

    logic                 in_beat;
    logic                 exp_start;
    logic [3:0]           exp_done;
    logic [47:0]          exp_val [4];
    logic                 mul_start;
    logic                 mul1_done;
    logic                 mul2_done;
    logic [63:0]          mul1_res;
    logic [63:0]          mul2_res;
    logic [51:0]          kt_prod;
    logic                 p_dep;
    logic                 t_dep;
    logic                 skip;
    logic [ENT_W:0]       p_chg;
    logic [ENT_W:0]       t_chg;
    logic                 mem_we;
    logic [IDX_W-1:0]     p_waddr;
    logic [IDX_W-1:0]     t_waddr;
    logic [ENT_W-1:0]     p_wdata;
    logic [ENT_W-1:0]     t_wdata;
    verdict_t             verdict_next;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign exp_start = (state_reg == ST_READ);
    assign mul_start = (state_reg == ST_MUL);

    // Four exponential units: exp(y1), exp(y2), exp(-y1), exp(-y2).
    mfb_exp u_exp_a (.clk(clk), .rst_n(rst_n), .start(exp_start), .y(y1_reg),
                     .done(exp_done[0]), .value(exp_val[0]));
    mfb_exp u_exp_b (.clk(clk), .rst_n(rst_n), .start(exp_start), .y(y2_reg),
                     .done(exp_done[1]), .value(exp_val[1]));
    mfb_exp u_exp_c (.clk(clk), .rst_n(rst_n), .start(exp_start), .y(17'd0 - y1_reg),
                     .done(exp_done[2]), .value(exp_val[2]));
    mfb_exp u_exp_d (.clk(clk), .rst_n(rst_n), .start(exp_start), .y(17'd0 - y2_reg),
                     .done(exp_done[3]), .value(exp_val[3]));

    // Fraction products x1 and x2.
    mfb_mulq u_mul1 (.clk(clk), .rst_n(rst_n), .start(mul_start), .a({20'd0, ratio_reg}),
                     .b(sum1_reg), .done(mul1_done), .result(mul1_res));
    mfb_mulq u_mul2 (.clk(clk), .rst_n(rst_n), .start(mul_start), .a({20'd0, ratio_reg}),
                     .b(sum2_reg), .done(mul2_done), .result(mul2_res));

    // Depletion check, charge results and memory write port.
    always_comb
    begin
        kt_prod = kt_reg * inverse_energy_reg;
        p_dep   = (pent_reg[ENT_W-1 -: EPOCH_W] == epoch_reg) && pent_reg[SUM_WIDTH];
        t_dep   = (tent_reg[ENT_W-1 -: EPOCH_W] == epoch_reg) && tent_reg[SUM_WIDTH];
        skip    = deplete_enable_reg && (p_dep || t_dep);
        p_chg   = charge(pent_reg, x1_reg, epoch_reg, deplete_enable_reg);
        t_chg   = charge(tent_reg, x2_reg, epoch_reg, deplete_enable_reg);
        priority if (p_chg[ENT_W] && t_chg[ENT_W])
            verdict_next = VERDICT_BOTH;
        else if (p_chg[ENT_W])
            verdict_next = VERDICT_P_OVER;
        else if (t_chg[ENT_W])
            verdict_next = VERDICT_T_OVER;
        else
            verdict_next = VERDICT_KEPT;
        mem_we = (state_reg == ST_SWEEP) || (state_reg == ST_CHG);
        if (state_reg == ST_SWEEP)
        begin
            p_waddr = sweep_cnt_reg;
            t_waddr = sweep_cnt_reg;
            p_wdata = '0;
            t_wdata = '0;
        end
        else
        begin
            p_waddr = p_idx_reg;
            t_waddr = t_idx_reg;
            p_wdata = p_chg[ENT_W-1:0];
            t_wdata = t_chg[ENT_W-1:0];
        end
    end

    // Slot memories with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pmem[p_waddr] <= p_wdata;
            tmem[t_waddr] <= t_wdata;
        end
        pent_reg <= pmem[p_idx_reg];
        tent_reg <= tmem[t_idx_reg];
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverse_energy_reg <= INVERSE_ENERGY_RESET;
            deplete_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INVERSE_ENERGY: inverse_energy_reg <= cfg_data;
                CFG_DEPLETE_ENABLE: deplete_enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Item sequencer, event tag and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            busy_reg      <= 1'b0;
            sweep_cnt_reg <= '0;
            epoch_reg     <= EPOCH_FIRST;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            // A finished item refills the output register as it empties.
            if ((state_reg == ST_DONE) && (!m_tvalid_reg || m_tready))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_SWEEP:
                begin
                    if (sweep_cnt_reg == LAST_SLOT)
                    begin
                        sweep_cnt_reg <= '0;
                        epoch_reg     <= EPOCH_FIRST;
                        state_reg     <= busy_reg ? ST_READ : ST_IDLE;
                    end
                    else
                    begin
                        sweep_cnt_reg <= sweep_cnt_reg + IDX_W'(1);
                    end
                end
                ST_IDLE:
                begin
                    if (in_beat)
                    begin
                        busy_reg <= 1'b1;
                        if (s_tuser && (epoch_reg == EPOCH_LAST))
                        begin
                            state_reg <= ST_SWEEP;
                        end
                        else
                        begin
                            if (s_tuser)
                            begin
                                epoch_reg <= epoch_reg + EPOCH_FIRST;
                            end
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ:  state_reg <= ST_CHECK;
                ST_CHECK: state_reg <= skip ? ST_DONE : ST_EXP;
                ST_EXP:
                begin
                    if (&exp_done)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:   state_reg <= ST_MULW;
                ST_MULW:
                begin
                    if (mul1_done && mul2_done)
                    begin
                        state_reg <= ST_CHG;
                    end
                end
                ST_CHG:   state_reg <= ST_DONE;
                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        busy_reg  <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    // Item data path registers.
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            kt_reg    <= s_tdata[19:0];
            y1_reg    <= {s_tdata[35], s_tdata[35:20]};
            y2_reg    <= {s_tdata[51], s_tdata[51:36]};
            p_idx_reg <= IDX_W'(slot_of(s_tdata[59:52]));
            t_idx_reg <= IDX_W'(slot_of(s_tdata[67:60]));
        end
        if (state_reg == ST_READ)
        begin
            ratio_reg <= kt_prod[51:8];
        end
        if (state_reg == ST_CHECK)
        begin
            accepted_reg <= 1'b0;
            verdict_reg  <= VERDICT_SKIPPED;
        end
        if ((state_reg == ST_EXP) && (&exp_done))
        begin
            sum1_reg <= {16'd0, exp_val[0]} + {16'd0, exp_val[1]};
            sum2_reg <= {16'd0, exp_val[2]} + {16'd0, exp_val[3]};
        end
        if ((state_reg == ST_MULW) && mul1_done && mul2_done)
        begin
            x1_reg <= to_sum(mul1_res);
            x2_reg <= to_sum(mul2_res);
        end
        if (state_reg == ST_CHG)
        begin
            accepted_reg <= (verdict_next == VERDICT_KEPT);
            verdict_reg  <= verdict_next;
        end
        if ((state_reg == ST_DONE) && (!m_tvalid_reg || m_tready))
        begin
            m_tdata_reg <= {4'd0, verdict_reg, accepted_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

### sv/mfb_checker.sv
// Port-level checker for the momentum fraction budget filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mfb_checker
    import mfb_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // A stalled result beat holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // The accepted flag agrees with the verdict code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == VERDICT_KEPT)))
        else $error("accepted flag disagrees with verdict");

    // Only defined verdict codes leave the block, with zero fill above.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[3:1] == VERDICT_KEPT) || (m_tdata[3:1] == VERDICT_SKIPPED) ||
                      (m_tdata[3:1] == VERDICT_P_OVER) || (m_tdata[3:1] == VERDICT_T_OVER) ||
                      (m_tdata[3:1] == VERDICT_BOTH)) && (m_tdata[7:4] == 4'd0))
        else $error("undefined verdict code");

    // One item is worked on at a time: input closes right after a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

endmodule

bind momentum_fraction_budget_filter mfb_checker u_mfb_checker (.*);

`default_nettype wire
